FILE: design/ps2mt_pkg.sv
package ps2mt_pkg;

  // Register file geometry
  localparam int LIMIT_BITS = 12;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_SCREEN_WIDTH = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [LIMIT_BITS-1:0] SCREEN_WIDTH_RESET = 12'd80;
  localparam logic [LIMIT_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd25;

  // Stream widths
  localparam int BYTE_BITS = 8;
  localparam int POS_OUT_BITS = 12;
  localparam int RESULT_BITS = 4 * POS_OUT_BITS + 3;
  localparam int RESULT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

  // Status byte button masks
  localparam logic [BYTE_BITS-1:0] BTN_LEFT = 8'h01;
  localparam logic [BYTE_BITS-1:0] BTN_RIGHT = 8'h02;
  localparam logic [BYTE_BITS-1:0] BTN_MIDDLE = 8'h04;
  localparam logic [BYTE_BITS-1:0] BTN_MASK = BTN_LEFT | BTN_RIGHT | BTN_MIDDLE;

  // Position within the three-byte packet
  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] screen_width;
    logic [LIMIT_BITS-1:0] screen_height;
  } limits_t;

  typedef struct packed {
    logic                    middle_pressed;
    logic                    right_pressed;
    logic                    left_pressed;
    logic [POS_OUT_BITS-1:0] previous_y;
    logic [POS_OUT_BITS-1:0] previous_x;
    logic [POS_OUT_BITS-1:0] cursor_y;
    logic [POS_OUT_BITS-1:0] cursor_x;
  } result_t;

endpackage

FILE: design/ps2mt_cfg_regs.sv
module ps2mt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ps2mt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [ps2mt_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [ps2mt_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                pready,
  output ps2mt_pkg::limits_t                  limits
);

  logic                                wr_en;
  logic                                reg_sel;
  logic [ps2mt_pkg::LIMIT_BITS-1:0]    screen_width;
  logic [ps2mt_pkg::LIMIT_BITS-1:0]    screen_height;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Write the addressed limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ps2mt_pkg::SCREEN_WIDTH_RESET;
      screen_height <= ps2mt_pkg::SCREEN_HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        ps2mt_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[ps2mt_pkg::LIMIT_BITS-1:0];
        ps2mt_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[ps2mt_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      ps2mt_pkg::REG_SCREEN_WIDTH:  prdata = ps2mt_pkg::APB_DATA_BITS'(screen_width);
      ps2mt_pkg::REG_SCREEN_HEIGHT: prdata = ps2mt_pkg::APB_DATA_BITS'(screen_height);
      default:                      prdata = '0;
    endcase
  end

  assign limits.screen_width  = screen_width;
  assign limits.screen_height = screen_height;

endmodule

FILE: design/ps2mt_core.sv
module ps2mt_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  input  logic [ps2mt_pkg::BYTE_BITS-1:0] data_byte,
  output logic                            byte_ready,
  input  logic                            slot_free,
  input  ps2mt_pkg::limits_t              limits,
  output logic                            result_load,
  output ps2mt_pkg::result_t              result
);

  // Wide enough for position plus a signed byte, and for the limits
  localparam int SW = ((COORD_BITS > ps2mt_pkg::LIMIT_BITS) ? COORD_BITS
                                                            : ps2mt_pkg::LIMIT_BITS) + 2;

  ps2mt_pkg::phase_t                phase;
  ps2mt_pkg::phase_t                phase_next;
  logic [2:0]                       button_flags;
  logic [ps2mt_pkg::BYTE_BITS-1:0]  held_x_delta;
  logic [COORD_BITS-1:0]            pos_x;
  logic [COORD_BITS-1:0]            pos_y;
  logic [COORD_BITS-1:0]            pos_x_next;
  logic [COORD_BITS-1:0]            pos_y_next;
  logic                             accept;
  logic                             is_status;
  logic                             is_xdelta;
  logic                             is_ydelta;
  logic signed [SW-1:0]             sum_x;
  logic signed [SW-1:0]             sum_y;
  logic signed [SW-1:0]             lim_x;
  logic signed [SW-1:0]             lim_y;

  // A result byte needs the output slot; header and X bytes never wait
  assign byte_ready = (phase != ps2mt_pkg::PH_YDELTA) || slot_free;
  assign accept     = byte_valid && byte_ready;

  // Next phase
  always_comb begin
    unique case (phase)
      ps2mt_pkg::PH_STATUS: phase_next = ps2mt_pkg::PH_XDELTA;
      ps2mt_pkg::PH_XDELTA: phase_next = ps2mt_pkg::PH_YDELTA;
      ps2mt_pkg::PH_YDELTA: phase_next = ps2mt_pkg::PH_STATUS;
      default:              phase_next = ps2mt_pkg::PH_XDELTA;
    endcase
  end

  // Decode what the current byte is; an unknown phase counts as a status byte
  always_comb begin
    is_status = 1'b0;
    is_xdelta = 1'b0;
    is_ydelta = 1'b0;
    unique case (phase)
      ps2mt_pkg::PH_XDELTA: is_xdelta = 1'b1;
      ps2mt_pkg::PH_YDELTA: is_ydelta = 1'b1;
      default:              is_status = 1'b1;
    endcase
  end

  // Move and clamp both axes
  always_comb begin
    sum_x = $signed(SW'(pos_x)) + SW'($signed(held_x_delta));
    sum_y = $signed(SW'(pos_y)) - SW'($signed(data_byte));
    lim_x = $signed(SW'(limits.screen_width));
    lim_y = $signed(SW'(limits.screen_height));

    if (sum_x < 0) begin
      pos_x_next = '0;
    end else if (sum_x > lim_x) begin
      pos_x_next = (limits.screen_width < 12'd2) ? '0
                 : COORD_BITS'(limits.screen_width - 12'd2);
    end else begin
      pos_x_next = COORD_BITS'(sum_x);
    end

    if (sum_y < 0) begin
      pos_y_next = '0;
    end else if (sum_y > lim_y) begin
      pos_y_next = (limits.screen_height < 12'd2) ? '0
                 : COORD_BITS'(limits.screen_height - 12'd2);
    end else begin
      pos_y_next = COORD_BITS'(sum_y);
    end
  end

  // Result fields
  always_comb begin
    result_load           = accept && is_ydelta;
    result.cursor_x       = ps2mt_pkg::POS_OUT_BITS'(pos_x_next);
    result.cursor_y       = ps2mt_pkg::POS_OUT_BITS'(pos_y_next);
    result.previous_x     = ps2mt_pkg::POS_OUT_BITS'(pos_x);
    result.previous_y     = ps2mt_pkg::POS_OUT_BITS'(pos_y);
    result.left_pressed   = button_flags[0];
    result.right_pressed  = button_flags[1];
    result.middle_pressed = button_flags[2];
  end

  // Advance packet state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ps2mt_pkg::PH_STATUS;
      button_flags <= '0;
      held_x_delta <= '0;
      pos_x        <= '0;
      pos_y        <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (is_status) begin
        button_flags <= 3'(data_byte & ps2mt_pkg::BTN_MASK);
      end
      if (is_xdelta) begin
        held_x_delta <= data_byte;
      end
      if (is_ydelta) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
    end
  end

endmodule

FILE: design/ps2mt_out_reg.sv
module ps2mt_out_reg (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    load,
  input  ps2mt_pkg::result_t                      result,
  output logic                                    slot_free,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [ps2mt_pkg::RESULT_TDATA_BITS-1:0] m_tdata
);

  logic               out_valid;
  ps2mt_pkg::result_t out_data;

  // Slot frees when empty or when the held result is taken this cycle
  assign slot_free = !out_valid || m_tready;

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = ps2mt_pkg::RESULT_TDATA_BITS'(out_data);

endmodule

FILE: design/ps2_mouse_packet_tracker.sv
// Channel   Dir  Width  Contents
// s_axis    in   8      one mouse byte (status, X delta, Y delta in turn)
// m_axis    out  56     cursor and previous positions, buttons; one per packet
// apb       in   3/32   screen_width at 0x0, screen_height at 0x4
//
// One byte is taken per cycle; the position add and clamp sit between the
// packet state registers and the output register, so a result appears the
// cycle after its Y byte is accepted. Reset (rst, synchronous) clears the
// packet phase, buttons and position and loads the default screen limits.
// Only a Y byte waits for a stalled output; status and X bytes always pass.
module ps2_mouse_packet_tracker #(
  parameter int COORD_BITS = 12
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // data_byte[7:0]
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [ps2mt_pkg::BYTE_BITS-1:0]         s_tdata,
  // cursor_x[11:0], cursor_y[23:12], previous_x[35:24], previous_y[47:36],
  // left_pressed[48], right_pressed[49], middle_pressed[50], zero[55:51]
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [ps2mt_pkg::RESULT_TDATA_BITS-1:0] m_tdata,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [ps2mt_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [ps2mt_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [ps2mt_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                    pready
);

  ps2mt_pkg::limits_t limits;
  ps2mt_pkg::result_t result;
  logic               result_load;
  logic               slot_free;

  ps2mt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  ps2mt_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (s_tvalid),
    .data_byte   (s_tdata),
    .byte_ready  (s_tready),
    .slot_free   (slot_free),
    .limits      (limits),
    .result_load (result_load),
    .result      (result)
  );

  ps2mt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (result_load),
    .result    (result),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: bench/testbench.sv
module testbench;

  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 600;
  localparam int MAX_CHUNK = 150;

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    s_tvalid = 1'b0;
  logic                                    s_tready;
  logic [ps2mt_pkg::BYTE_BITS-1:0]         s_tdata = '0;
  logic                                    m_tvalid;
  logic                                    m_tready = 1'b0;
  logic [ps2mt_pkg::RESULT_TDATA_BITS-1:0] m_tdata;
  logic                                    psel = 1'b0;
  logic                                    penable = 1'b0;
  logic                                    pwrite = 1'b0;
  logic [ps2mt_pkg::APB_ADDR_BITS-1:0]     paddr = '0;
  logic [ps2mt_pkg::APB_DATA_BITS-1:0]     pwdata = '0;
  logic [ps2mt_pkg::APB_DATA_BITS-1:0]     prdata;
  logic                                    pready;

  // Bytes waiting to be offered, and reports still owed by the block
  logic [ps2mt_pkg::BYTE_BITS-1:0] mouse_bytes[$];
  ps2mt_pkg::result_t              expected_reports[$];
  logic                            byte_taken = 1'b0;
  int                              send_idle_pct = 0;
  int                              recv_idle_pct = 0;
  int                              mismatch_count = 0;

  // Shadow of the tracker: packet phase, latched buttons, held X, cursor, limits
  ps2mt_pkg::phase_t                mouse_phase = ps2mt_pkg::PH_STATUS;
  logic [2:0]                       btn_latch = '0;
  logic [ps2mt_pkg::BYTE_BITS-1:0]  x_held = '0;
  logic [ps2mt_pkg::LIMIT_BITS-1:0] cur_x = '0;
  logic [ps2mt_pkg::LIMIT_BITS-1:0] cur_y = '0;
  logic [ps2mt_pkg::LIMIT_BITS-1:0] width_lim = ps2mt_pkg::SCREEN_WIDTH_RESET;
  logic [ps2mt_pkg::LIMIT_BITS-1:0] height_lim = ps2mt_pkg::SCREEN_HEIGHT_RESET;

  // Hand-picked packets: edge-equal limit, over-limit, negative, no/single/all buttons
  logic [ps2mt_pkg::BYTE_BITS-1:0] probe_packets[21] = '{
    8'h07, 8'h50, 8'h00,
    8'h00, 8'h01, 8'hE7,
    8'hFF, 8'h80, 8'h80,
    8'h01, 8'h7F, 8'h7F,
    8'h02, 8'h00, 8'h00,
    8'h04, 8'hFF, 8'hFF,
    8'hF8, 8'h02, 8'h01
  };

  int send_pcts[3] = '{25, 75, 0};
  int recv_pcts[3] = '{75, 25, 0};

  ps2_mouse_packet_tracker uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Clamp one axis: negative to zero, above the limit to limit minus two
  function automatic logic [ps2mt_pkg::LIMIT_BITS-1:0] clamp_axis_to(
      input int v, input logic [ps2mt_pkg::LIMIT_BITS-1:0] limit);
    if (v < 0) return '0;
    if (v > int'(limit)) begin
      return (limit < 2) ? '0 : limit - ps2mt_pkg::LIMIT_BITS'(2);
    end
    return v[ps2mt_pkg::LIMIT_BITS-1:0];
  endfunction

  // Advance the shadow by one accepted byte; queue a report on the Y byte
  function automatic void track_byte(input logic [ps2mt_pkg::BYTE_BITS-1:0] b);
    ps2mt_pkg::result_t rep;
    int                 dx;
    int                 dy;
    case (mouse_phase)
      ps2mt_pkg::PH_XDELTA: begin
        x_held = b;
        mouse_phase = ps2mt_pkg::PH_YDELTA;
      end
      ps2mt_pkg::PH_YDELTA: begin
        dx = int'($signed(x_held));
        dy = int'($signed(b));
        rep.previous_x = cur_x;
        rep.previous_y = cur_y;
        rep.cursor_x = clamp_axis_to(int'(cur_x) + dx, width_lim);
        rep.cursor_y = clamp_axis_to(int'(cur_y) - dy, height_lim);
        rep.left_pressed = (btn_latch & ps2mt_pkg::BTN_LEFT[2:0]) != 0;
        rep.right_pressed = (btn_latch & ps2mt_pkg::BTN_RIGHT[2:0]) != 0;
        rep.middle_pressed = (btn_latch & ps2mt_pkg::BTN_MIDDLE[2:0]) != 0;
        cur_x = rep.cursor_x;
        cur_y = rep.cursor_y;
        expected_reports.push_back(rep);
        mouse_phase = ps2mt_pkg::PH_STATUS;
      end
      default: begin
        btn_latch = b[2:0] & ps2mt_pkg::BTN_MASK[2:0];
        mouse_phase = ps2mt_pkg::PH_XDELTA;
      end
    endcase
  endfunction

  function automatic void check_field(input string name,
                                      input logic [ps2mt_pkg::LIMIT_BITS-1:0] want,
                                      input logic [ps2mt_pkg::LIMIT_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Random bytes mixed with extremes, small moves and a per-chunk drift
  function automatic logic [ps2mt_pkg::BYTE_BITS-1:0] pick_byte(
      input logic [ps2mt_pkg::BYTE_BITS-1:0] drift);
    case ($urandom_range(0, 4))
      0, 1: return ps2mt_pkg::BYTE_BITS'($urandom_range(0, 255));
      2: begin
        case ($urandom_range(0, 3))
          0: return 8'h7F;
          1: return 8'h80;
          2: return 8'h00;
          default: return 8'hFF;
        endcase
      end
      3: return ps2mt_pkg::BYTE_BITS'(int'($urandom_range(0, 16)) - 8);
      default: return drift;
    endcase
  endfunction

  function automatic logic [ps2mt_pkg::LIMIT_BITS-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return ps2mt_pkg::LIMIT_BITS'($urandom_range(0, 1));
      1: return '1;
      2: return ps2mt_pkg::LIMIT_BITS'(2);
      3: return ps2mt_pkg::LIMIT_BITS'($urandom_range(0, 4095));
      default: return ps2mt_pkg::LIMIT_BITS'($urandom_range(2, 600));
    endcase
  endfunction

  // Drive byte requests; hold each one until it is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || byte_taken) begin
      if (mouse_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= mouse_bytes.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the report side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Predict on each accepted byte, then check each accepted report
  always @(posedge clk) begin : report_check
    ps2mt_pkg::result_t got;
    ps2mt_pkg::result_t want;
    byte_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      track_byte(s_tdata);
    end
    if (!rst && m_tvalid && m_tready) begin
      got = ps2mt_pkg::result_t'(m_tdata[ps2mt_pkg::RESULT_BITS-1:0]);
      if (expected_reports.size() == 0) begin
        $error("report: none expected, got cursor %0d,%0d", got.cursor_x, got.cursor_y);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("cursor_x", want.cursor_x, got.cursor_x);
        check_field("cursor_y", want.cursor_y, got.cursor_y);
        check_field("previous_x", want.previous_x, got.previous_x);
        check_field("previous_y", want.previous_y, got.previous_y);
        check_field("left_pressed", ps2mt_pkg::LIMIT_BITS'(want.left_pressed),
                    ps2mt_pkg::LIMIT_BITS'(got.left_pressed));
        check_field("right_pressed", ps2mt_pkg::LIMIT_BITS'(want.right_pressed),
                    ps2mt_pkg::LIMIT_BITS'(got.right_pressed));
        check_field("middle_pressed", ps2mt_pkg::LIMIT_BITS'(want.middle_pressed),
                    ps2mt_pkg::LIMIT_BITS'(got.middle_pressed));
      end
    end
  end

  // Hold until every byte is taken and every report is back, then let it settle
  task automatic wait_drained();
    do @(negedge clk);
    while (mouse_bytes.size() != 0 || s_tvalid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [ps2mt_pkg::APB_ADDR_BITS-1:0] addr,
                          input logic [ps2mt_pkg::APB_DATA_BITS-1:0] wdata,
                          output logic [ps2mt_pkg::APB_DATA_BITS-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write one limit, mirror it in the shadow, and read it back
  task automatic set_limit(input logic reg_idx,
                           input logic [ps2mt_pkg::LIMIT_BITS-1:0] value);
    logic [ps2mt_pkg::APB_DATA_BITS-1:0] rd;
    apb_xfer(1'b1, {reg_idx, 2'b00}, ps2mt_pkg::APB_DATA_BITS'(value), rd);
    if (reg_idx == ps2mt_pkg::REG_SCREEN_WIDTH) width_lim = value;
    else height_lim = value;
    apb_xfer(1'b0, {reg_idx, 2'b00}, '0, rd);
    if (rd !== ps2mt_pkg::APB_DATA_BITS'(value)) begin
      $error("prdata: expected %0d, got %0d", value, rd);
      mismatch_count++;
    end
  endtask

  // Feed random chunks, pausing for all reports after each, sometimes retuning
  task automatic run_random(input int total);
    int                              left;
    int                              chunk;
    logic [ps2mt_pkg::BYTE_BITS-1:0] drift;
    left = total;
    while (left > 0) begin
      chunk = $urandom_range(1, MAX_CHUNK);
      if (chunk > left) chunk = left;
      drift = $urandom_range(0, 1) ? 8'h7F : 8'h80;
      repeat (chunk) mouse_bytes.push_back(pick_byte(drift));
      left -= chunk;
      wait_drained();
      if ($urandom_range(0, 3) == 0) begin
        set_limit($urandom_range(0, 1) ? ps2mt_pkg::REG_SCREEN_WIDTH
                                       : ps2mt_pkg::REG_SCREEN_HEIGHT, pick_limit());
      end
    end
  endtask

  initial begin
    send_idle_pct = send_pcts[0];
    recv_idle_pct = recv_pcts[0];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed packets at the reset limits
    foreach (probe_packets[i]) mouse_bytes.push_back(probe_packets[i]);
    wait_drained();

    // Limits below two saturate to zero
    set_limit(ps2mt_pkg::REG_SCREEN_WIDTH, ps2mt_pkg::LIMIT_BITS'(1));
    set_limit(ps2mt_pkg::REG_SCREEN_HEIGHT, ps2mt_pkg::LIMIT_BITS'(0));
    mouse_bytes.push_back(8'h03);
    mouse_bytes.push_back(8'h7F);
    mouse_bytes.push_back(8'h80);
    wait_drained();
    set_limit(ps2mt_pkg::REG_SCREEN_WIDTH, '1);
    set_limit(ps2mt_pkg::REG_SCREEN_HEIGHT, '1);

    // Random phases under each idling mix
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pcts[p];
      recv_idle_pct = recv_pcts[p];
      set_limit(ps2mt_pkg::REG_SCREEN_WIDTH, pick_limit());
      set_limit(ps2mt_pkg::REG_SCREEN_HEIGHT, pick_limit());
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
